### rtl/core/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// shared types and constants of the carrier diffusion stencil
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int GRID_WIDTH_DEF  = 32;
   localparam int GRID_HEIGHT_DEF = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [13:0] DIFF_MAX = 14'd15728;
   localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] REG_DIFF_GAIN     = 3'd0;
   localparam logic [2:0] REG_DECAY_GAIN    = 3'd1;
   localparam logic [2:0] REG_GEN_GAIN      = 3'd2;
   localparam logic [2:0] REG_BJT_MODE      = 3'd3;
   localparam logic [2:0] REG_EMITTER_LEVEL = 3'd4;
   localparam logic [2:0] REG_SWEEP_GAIN    = 3'd5;
   localparam logic [2:0] REG_EMITTER_END   = 3'd6;
   localparam logic [2:0] REG_BASE_END      = 3'd7;

   localparam logic ST_STREAM = 1'b0;
   localparam logic ST_FLUSH  = 1'b1;

   typedef struct packed {
      logic [13:0] diff_gain;
      logic [15:0] decay_gain;
      logic [23:0] gen_gain;
      logic        bjt_mode;
      logic [31:0] emitter_level;
      logic [15:0] sweep_gain;
      logic [5:0]  emitter_end;
      logic [5:0]  base_end;
   } cfg_type;

   typedef struct packed {
      logic [31:0] c;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] u;
      logic [31:0] d;
      logic [31:0] g;
      logic        emit;
      logic        coll;
      logic        last;
   } task_type;

endpackage

### rtl/core/cds_req_if.sv
// ----------------------------------------------------------------------------
// cds_req_if
// input channel: one grid cell per transaction
// ----------------------------------------------------------------------------
interface cds_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] density;
   logic [31:0] generation;

   modport source (output valid, density, generation, input ready);
   modport sink   (input valid, density, generation, output ready);
endinterface

### rtl/core/cds_rsp_if.sv
// ----------------------------------------------------------------------------
// cds_rsp_if
// result channel: one updated cell per transaction
// ----------------------------------------------------------------------------
interface cds_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_density;
   logic [47:0] swept_total;
   logic        frame_last;

   modport source (output valid, new_density, swept_total, frame_last, input ready);
   modport sink   (input valid, new_density, swept_total, frame_last, output ready);
endinterface

### rtl/core/cds_csr.sv
// ----------------------------------------------------------------------------
// cds_csr
// apb register file holding the stencil configuration
// ----------------------------------------------------------------------------
module cds_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cds_pkg::cfg_type  cfg
);

   cds_pkg::cfg_type cfg_ff;
   cds_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            cds_pkg::REG_DIFF_GAIN:     cfg_in.diff_gain     = csr_pwdata[13:0];
            cds_pkg::REG_DECAY_GAIN:    cfg_in.decay_gain    = csr_pwdata[15:0];
            cds_pkg::REG_GEN_GAIN:      cfg_in.gen_gain      = csr_pwdata[23:0];
            cds_pkg::REG_BJT_MODE:      cfg_in.bjt_mode      = csr_pwdata[0];
            cds_pkg::REG_EMITTER_LEVEL: cfg_in.emitter_level = csr_pwdata;
            cds_pkg::REG_SWEEP_GAIN:    cfg_in.sweep_gain    = csr_pwdata[15:0];
            cds_pkg::REG_EMITTER_END:   cfg_in.emitter_end   = csr_pwdata[5:0];
            cds_pkg::REG_BASE_END:      cfg_in.base_end      = csr_pwdata[5:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         cds_pkg::REG_DIFF_GAIN:     csr_prdata = 32'(cfg_ff.diff_gain);
         cds_pkg::REG_DECAY_GAIN:    csr_prdata = 32'(cfg_ff.decay_gain);
         cds_pkg::REG_GEN_GAIN:      csr_prdata = 32'(cfg_ff.gen_gain);
         cds_pkg::REG_BJT_MODE:      csr_prdata = 32'(cfg_ff.bjt_mode);
         cds_pkg::REG_EMITTER_LEVEL: csr_prdata = cfg_ff.emitter_level;
         cds_pkg::REG_SWEEP_GAIN:    csr_prdata = 32'(cfg_ff.sweep_gain);
         cds_pkg::REG_EMITTER_END:   csr_prdata = 32'(cfg_ff.emitter_end);
         cds_pkg::REG_BASE_END:      csr_prdata = 32'(cfg_ff.base_end);
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diff_gain     <= 14'd2621;
         cfg_ff.decay_gain    <= 16'd0;
         cfg_ff.gen_gain      <= 24'd0;
         cfg_ff.bjt_mode      <= 1'b0;
         cfg_ff.emitter_level <= 32'd39322;
         cfg_ff.sweep_gain    <= 16'd0;
         cfg_ff.emitter_end   <= 6'd7;
         cfg_ff.base_end      <= 6'd9;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/cds_front.sv
// ----------------------------------------------------------------------------
// cds_front
// accepts cells, keeps the line buffers and builds one stencil task per result
// ----------------------------------------------------------------------------
module cds_front #(
   parameter int GRID_WIDTH  = cds_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = cds_pkg::GRID_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   cds_req_if.sink           req_if,
   input  cds_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              push,
   output cds_pkg::task_type push_task
);

   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;
   localparam int LINE_N = 2 * GRID_WIDTH;

   logic [31:0]      line_ff [LINE_N];
   logic [31:0]      gline_ff [GRID_WIDTH];
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             st_ff, st_in;
   logic             accept, flush_step, shift, col_end;
   logic [31:0]      c_tap, g_tap, d_new, g_new;

   assign accept     = req_if.valid && req_if.ready;
   assign req_if.ready = (st_ff == cds_pkg::ST_STREAM) && !q_full;
   assign flush_step = (st_ff == cds_pkg::ST_FLUSH) && !q_full;
   assign shift      = accept || flush_step;
   assign col_end    = col_ff == COL_W'(GRID_WIDTH - 1);

   assign c_tap = line_ff[GRID_WIDTH-1];
   assign g_tap = gline_ff[GRID_WIDTH-1];
   assign d_new = accept ? req_if.density : c_tap;
   assign g_new = accept ? req_if.generation : g_tap;

   assign push = (accept && row_ff != '0) || flush_step;

   always_comb begin
      logic is_emit;
      is_emit = cfg.bjt_mode && (7'(col_ff) < 7'(cfg.emitter_end));
      push_task.c    = c_tap;
      push_task.l    = (col_ff == '0) ? c_tap : line_ff[GRID_WIDTH];
      push_task.r    = col_end ? c_tap : line_ff[GRID_WIDTH-2];
      push_task.u    = ((st_ff == cds_pkg::ST_STREAM) && row_ff == ROW_W'(1))
                       ? c_tap : line_ff[LINE_N-1];
      push_task.d    = (st_ff == cds_pkg::ST_FLUSH) ? c_tap : req_if.density;
      push_task.g    = g_tap;
      push_task.emit = is_emit;
      push_task.coll = cfg.bjt_mode && !is_emit && (7'(col_ff) >= 7'(cfg.base_end));
      push_task.last = (st_ff == cds_pkg::ST_FLUSH) && col_end;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      st_in  = st_ff;
      if (shift) begin
         col_in = col_end ? '0 : col_ff + COL_W'(1);
      end
      unique case (st_ff)
         cds_pkg::ST_STREAM: begin
            if (accept && col_end) begin
               if (row_ff == ROW_W'(GRID_HEIGHT - 1)) begin
                  row_in = '0;
                  st_in  = cds_pkg::ST_FLUSH;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         cds_pkg::ST_FLUSH: begin
            if (flush_step && col_end) begin
               st_in = cds_pkg::ST_STREAM;
            end
         end
         default: st_in = cds_pkg::ST_STREAM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         st_ff  <= cds_pkg::ST_STREAM;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         line_ff[0]  <= d_new;
         gline_ff[0] <= g_new;
         for (int k = 1; k < LINE_N; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
         for (int k = 1; k < GRID_WIDTH; k++) begin
            gline_ff[k] <= gline_ff[k-1];
         end
      end
   end

endmodule

### rtl/core/cds_queue.sv
// ----------------------------------------------------------------------------
// cds_queue
// short task queue between the front and the back
// ----------------------------------------------------------------------------
module cds_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cds_pkg::task_type push_task,
   input  logic              pop,
   output cds_pkg::task_type pop_task,
   output logic              full,
   output logic              empty
);

   cds_pkg::task_type              mem_ff [cds_pkg::QUEUE_DEPTH];
   logic [cds_pkg::QPTR_W-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [cds_pkg::QPTR_W:0]       cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign full     = cnt_ff == (cds_pkg::QPTR_W+1)'(cds_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_task = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (cds_pkg::QPTR_W+1)'(do_push) - (cds_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_task;
      end
   end

endmodule

### rtl/core/cds_back.sv
// ----------------------------------------------------------------------------
// cds_back
// stencil arithmetic pipeline, sweep accounting and result register
// ----------------------------------------------------------------------------
module cds_back (
   input  logic              clock,
   input  logic              reset,
   input  cds_pkg::cfg_type  cfg,
   input  cds_pkg::task_type pop_task,
   input  logic              q_empty,
   output logic              pop,
   cds_rsp_if.source         rsp_if
);

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff, rv_ff;

   // stage 1: laplacian
   logic signed [35:0] s1_lap_ff;
   logic [13:0]        s1_dg_ff;
   logic [31:0]        s1_c_ff, s1_g_ff;
   logic               s1_emit_ff, s1_coll_ff, s1_last_ff;
   logic [33:0]        sum4;

   // stage 2: products
   logic signed [50:0] s2_pd_ff;
   logic [55:0]        s2_pg_ff;
   logic [47:0]        s2_pk_ff;
   logic [31:0]        s2_c_ff;
   logic               s2_emit_ff, s2_coll_ff, s2_last_ff;

   // stage 3: sum, round, saturate
   logic [31:0]        s3_res_ff, res_in;
   logic               s3_emit_ff, s3_coll_ff, s3_last_ff;
   logic signed [57:0] v, vr;

   // stage 4: region rules
   logic [31:0]        s4_out_ff, out_in, kept;
   logic [31:0]        s4_add_ff, add_in;
   logic               s4_last_ff;
   logic [47:0]        kprod;

   // stage 5: result
   logic [31:0]        rd_ff;
   logic [47:0]        rs_ff;
   logic               rl_ff;
   logic [47:0]        sum_ff, sum_sat;
   logic [48:0]        sum_wide;

   assign en  = !rv_ff || rsp_if.ready;
   assign pop = en && !q_empty;

   assign rsp_if.valid       = rv_ff;
   assign rsp_if.new_density = rd_ff;
   assign rsp_if.swept_total = rs_ff;
   assign rsp_if.frame_last  = rl_ff;

   assign sum4 = 34'(pop_task.l) + 34'(pop_task.r) + 34'(pop_task.u) + 34'(pop_task.d);

   always_comb begin
      v = $signed(58'({s2_c_ff, 16'h0000})) + 58'(s2_pd_ff)
          + $signed(58'(s2_pg_ff)) - $signed(58'(s2_pk_ff));
      vr = v + 58'sd32768;
      if (v[57] || v == '0) begin
         res_in = 32'd0;
      end else if (vr[57:48] != '0) begin
         res_in = 32'hFFFF_FFFF;
      end else begin
         res_in = vr[47:16];
      end
   end

   always_comb begin
      logic [31:0] base;
      base   = s3_emit_ff ? cfg.emitter_level : s3_res_ff;
      kprod  = 48'(s3_res_ff) * 48'(cfg.sweep_gain) + 48'h8000;
      kept   = kprod[47:16];
      out_in = s3_coll_ff ? kept : base;
      add_in = s3_coll_ff ? s3_res_ff - kept : 32'd0;
   end

   assign sum_wide = 49'(sum_ff) + 49'(s4_add_ff);
   assign sum_sat  = sum_wide[48] ? cds_pkg::SUM_MAX : sum_wide[47:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         sum_ff <= '0;
      end else if (en) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         rv_ff <= v4_ff;
         if (v4_ff) begin
            sum_ff <= s4_last_ff ? '0 : sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_lap_ff  <= $signed(36'(sum4) - 36'({pop_task.c, 2'b00}));
         s1_dg_ff   <= (cfg.diff_gain > cds_pkg::DIFF_MAX) ? cds_pkg::DIFF_MAX : cfg.diff_gain;
         s1_c_ff    <= pop_task.c;
         s1_g_ff    <= pop_task.g;
         s1_emit_ff <= pop_task.emit;
         s1_coll_ff <= pop_task.coll;
         s1_last_ff <= pop_task.last;

         s2_pd_ff   <= s1_lap_ff * $signed({1'b0, s1_dg_ff});
         s2_pg_ff   <= 56'(s1_g_ff) * 56'(cfg.gen_gain);
         s2_pk_ff   <= 48'(s1_c_ff) * 48'(cfg.decay_gain);
         s2_c_ff    <= s1_c_ff;
         s2_emit_ff <= s1_emit_ff;
         s2_coll_ff <= s1_coll_ff;
         s2_last_ff <= s1_last_ff;

         s3_res_ff  <= res_in;
         s3_emit_ff <= s2_emit_ff;
         s3_coll_ff <= s2_coll_ff;
         s3_last_ff <= s2_last_ff;

         s4_out_ff  <= out_in;
         s4_add_ff  <= add_in;
         s4_last_ff <= s3_last_ff;

         rd_ff <= s4_out_ff;
         rs_ff <= s4_last_ff ? sum_sat : 48'd0;
         rl_ff <= s4_last_ff;
      end
   end

endmodule

### rtl/core/carrier_diffusion_stencil.sv
// ----------------------------------------------------------------------------
// carrier_diffusion_stencil
// five-point explicit diffusion substep over a raster stream of grid cells
// ----------------------------------------------------------------------------
// req_if takes one cell per transaction (density, generation) in raster order,
// GRID_WIDTH cells a row, GRID_HEIGHT rows a frame. rsp_if gives one updated
// density per transaction in raster order; frame_last marks the frame's final
// cell and swept_total then carries the collector charge of the frame.
// The cell of row j is produced when its southern neighbor of row j+1 arrives,
// so arriving cells of row 0 give no result; the frame's final cell starts a
// flush of the last row, during which req_if.ready stays low.
// Throughput is one cell per cycle while the queue is not full, apart from the
// flush of each frame. A transaction's task is written to the queue at the
// accepting edge, then passes five pipeline registers of the back part.
// csr_ is an apb port: registers at byte address 4*index, to be written by the
// user only while the block is idle; the block itself does not enforce this.
// Reset restores register defaults and empties counters, queue and pipeline.
// When rsp_if stalls, the pipeline holds, the queue fills and req_if.ready drops.
// ----------------------------------------------------------------------------
module carrier_diffusion_stencil #(
   parameter int GRID_WIDTH  = cds_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = cds_pkg::GRID_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cds_req_if.sink     req_if,
   cds_rsp_if.source   rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cds_pkg::cfg_type  cfg;
   cds_pkg::task_type push_task, pop_task;
   logic              push, pop, q_full, q_empty;

   cds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cds_front #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cfg       (cfg),
      .q_full    (q_full),
      .push      (push),
      .push_task (push_task)
   );

   cds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .pop_task  (pop_task),
      .full      (q_full),
      .empty     (q_empty)
   );

   cds_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .pop_task (pop_task),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

### rtl/core/cds_checker.sv
// ----------------------------------------------------------------------------
// cds_checker
// port level checks of the stencil, bound to the top level
// ----------------------------------------------------------------------------
module cds_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_density,
   input logic [47:0] rsp_swept_total,
   input logic        rsp_frame_last,
   input logic        csr_pready
);

   a_swept_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_last |-> rsp_swept_total == 48'd0)
      else $error("swept_total set on a non-final transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_density))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind carrier_diffusion_stencil cds_checker u_cds_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_new_density (rsp_if.new_density),
   .rsp_swept_total (rsp_if.swept_total),
   .rsp_frame_last  (rsp_if.frame_last),
   .csr_pready      (csr_pready)
);
